// ----- rtl/cfr_pkg.sv -----
// Package for the checksummed frame receiver: parse phases, result kinds,
// buffer size constants and register reset values.
// No dependencies.
`default_nettype none

package cfr_pkg;

  // Payload buffer size; a length byte above this is clamped
  localparam int unsigned MAX_PAYLOAD = 8;
  localparam int unsigned IDX_W       = $clog2(MAX_PAYLOAD);
  localparam int unsigned LEN_W       = 4;   // width of payload_length field
  localparam int unsigned SUM_W       = 16;
  localparam int unsigned WORD_W      = 32;

  // Configuration register file
  localparam int unsigned CFG_NUM   = 8;
  localparam int unsigned CFG_IDX_W = $clog2(CFG_NUM);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HEAD1      = 3'd0,
    REG_HEAD2      = 3'd1,
    REG_TAIL1      = 3'd2,
    REG_TAIL2      = 3'd3,
    REG_CODE_INT   = 3'd4,
    REG_CODE_FLOAT = 3'd5,
    REG_CODE_ACK   = 3'd6,
    REG_CODE_COUNT = 3'd7
  } reg_idx_t;

  localparam logic [7:0] CFG_RESET [CFG_NUM] = '{
    8'd170, 8'd85, 8'd13, 8'd10, 8'd0, 8'd1, 8'd2, 8'd3
  };

  // Expected lengths of the recognized frame types
  localparam logic [LEN_W-1:0] LEN_WORD  = LEN_W'(4);
  localparam logic [LEN_W-1:0] LEN_ACK   = LEN_W'(0);
  localparam logic [LEN_W-1:0] LEN_COUNT = LEN_W'(1);

  // Deframer phases
  typedef enum logic [3:0] {
    PH_HEAD1 = 4'd0,
    PH_HEAD2 = 4'd1,
    PH_TYPE  = 4'd2,
    PH_LEN   = 4'd3,
    PH_DATA  = 4'd4,
    PH_SUMHI = 4'd5,
    PH_SUMLO = 4'd6,
    PH_TAIL1 = 4'd7,
    PH_TAIL2 = 4'd8
  } phase_t;

  // Result kinds
  typedef enum logic [2:0] {
    KIND_INT     = 3'd0,
    KIND_FLOAT   = 3'd1,
    KIND_ACK     = 3'd2,
    KIND_COUNT   = 3'd3,
    KIND_SUM_ERR = 3'd4,
    KIND_UNKNOWN = 3'd5
  } kind_t;

endpackage

`default_nettype wire

// ----- rtl/checksummed_frame_receiver.sv -----
// Checksummed frame receiver: byte-serial deframer with a 16-bit sum check.
// Depends on cfr_pkg for phases, result kinds and constants.
`default_nettype none

// One received byte is taken per transaction, one per clock cycle. The
// deframer state and running sum update in the cycle a byte is accepted;
// the frame result is held in an output register. Bytes keep flowing while
// a result waits to be taken; the input stalls only when a stalled result
// is still held and the next byte is the second tail byte that could
// complete another frame. A frame yields exactly one result when its
// second tail byte matches; header or tail mismatches drop back to the
// hunt with no result. Lengths above MAX_PAYLOAD are clamped. The result
// appears in the cycle after the completing byte is accepted.
module checksummed_frame_receiver
  import cfr_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  // configuration write port
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]           cfg_data,
  // byte input channel
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [7:0]           rx_byte,
  // result channel
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [2:0]                frame_kind,
  output logic [WORD_W-1:0]         payload_value,
  output logic [7:0]                type_code,
  output logic [LEN_W-1:0]          payload_length,
  output logic [SUM_W-1:0]          sum_computed,
  output logic [SUM_W-1:0]          sum_received
);

  // Configuration registers
  logic [7:0] cfg_regs [CFG_NUM];

  // Deframer state
  phase_t             phase, phase_next;
  logic [7:0]         held_type, held_type_next;
  logic [LEN_W-1:0]   held_length, held_length_next;
  logic [LEN_W-1:0]   payload_index, payload_index_next;
  logic [SUM_W-1:0]   running_sum, running_sum_next;
  logic [SUM_W-1:0]   received_sum, received_sum_next;
  logic [7:0]         payload_store [MAX_PAYLOAD];

  logic               in_fire;
  logic               store_we;
  logic               frame_done;
  logic [LEN_W-1:0]   len_clamped;
  logic [LEN_W-1:0]   index_inc;
  kind_t              kind_calc;
  logic [WORD_W-1:0]  value_calc;
  logic [WORD_W-1:0]  be_word;
  logic               out_valid_next;

  assign in_stall = out_valid && out_stall && (phase == PH_TAIL2);
  assign in_fire  = in_valid && !in_stall;

  // Config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CFG_NUM; i++) cfg_regs[i] <= CFG_RESET[i];
    end else if (cfg_we) begin
      cfg_regs[cfg_index] <= cfg_data;
    end
  end

  assign len_clamped = (rx_byte > 8'(MAX_PAYLOAD)) ? LEN_W'(MAX_PAYLOAD)
                                                   : rx_byte[LEN_W-1:0];
  assign index_inc   = payload_index + LEN_W'(1);

  // Next phase and per-byte state updates
  always_comb begin
    phase_next         = phase;
    held_type_next     = held_type;
    held_length_next   = held_length;
    payload_index_next = payload_index;
    running_sum_next   = running_sum;
    received_sum_next  = received_sum;
    store_we           = 1'b0;
    frame_done         = 1'b0;
    if (in_fire) begin
      case (phase)
        PH_HEAD2: begin
          phase_next = (rx_byte == cfg_regs[REG_HEAD2]) ? PH_TYPE : PH_HEAD1;
        end
        PH_TYPE: begin
          held_type_next   = rx_byte;
          running_sum_next = SUM_W'(rx_byte);
          phase_next       = PH_LEN;
        end
        PH_LEN: begin
          held_length_next   = len_clamped;
          payload_index_next = '0;
          running_sum_next   = running_sum + SUM_W'(len_clamped);
          phase_next         = (len_clamped != '0) ? PH_DATA : PH_SUMHI;
        end
        PH_DATA: begin
          store_we           = (payload_index < LEN_W'(MAX_PAYLOAD));
          payload_index_next = index_inc;
          running_sum_next   = running_sum + SUM_W'(rx_byte);
          if (index_inc >= held_length) phase_next = PH_SUMHI;
        end
        PH_SUMHI: begin
          received_sum_next = {rx_byte, 8'h00};
          phase_next        = PH_SUMLO;
        end
        PH_SUMLO: begin
          received_sum_next = {received_sum[15:8], rx_byte};
          phase_next        = PH_TAIL1;
        end
        PH_TAIL1: begin
          phase_next = (rx_byte == cfg_regs[REG_TAIL1]) ? PH_TAIL2 : PH_HEAD1;
        end
        PH_TAIL2: begin
          phase_next = PH_HEAD1;
          frame_done = (rx_byte == cfg_regs[REG_TAIL2]);
        end
        default: begin
          phase_next = (rx_byte == cfg_regs[REG_HEAD1]) ? PH_HEAD2 : PH_HEAD1;
        end
      endcase
    end
  end

  // Frame classification from held state
  assign be_word = {payload_store[0], payload_store[1],
                    payload_store[2], payload_store[3]};

  always_comb begin
    value_calc = '0;
    if (running_sum != received_sum) begin
      kind_calc = KIND_SUM_ERR;
    end else if (held_type == cfg_regs[REG_CODE_INT] && held_length == LEN_WORD) begin
      kind_calc  = KIND_INT;
      value_calc = be_word;
    end else if (held_type == cfg_regs[REG_CODE_FLOAT] && held_length == LEN_WORD) begin
      kind_calc  = KIND_FLOAT;
      value_calc = be_word;
    end else if (held_type == cfg_regs[REG_CODE_ACK] && held_length == LEN_ACK) begin
      kind_calc = KIND_ACK;
    end else if (held_type == cfg_regs[REG_CODE_COUNT] && held_length == LEN_COUNT) begin
      kind_calc  = KIND_COUNT;
      value_calc = WORD_W'(payload_store[0]);
    end else begin
      kind_calc = KIND_UNKNOWN;
    end
  end

  assign out_valid_next = frame_done || (out_valid && out_stall);

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HEAD1;
      held_type     <= '0;
      held_length   <= '0;
      payload_index <= '0;
      running_sum   <= '0;
      received_sum  <= '0;
      out_valid     <= 1'b0;
    end else begin
      phase         <= phase_next;
      held_type     <= held_type_next;
      held_length   <= held_length_next;
      payload_index <= payload_index_next;
      running_sum   <= running_sum_next;
      received_sum  <= received_sum_next;
      out_valid     <= out_valid_next;
    end
  end

  // Payload buffer, no reset
  always_ff @(posedge clk) begin
    if (store_we) payload_store[payload_index[IDX_W-1:0]] <= rx_byte;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (frame_done) begin
      frame_kind     <= kind_calc;
      payload_value  <= value_calc;
      type_code      <= held_type;
      payload_length <= held_length;
      sum_computed   <= running_sum;
      sum_received   <= received_sum;
    end
  end

  // A result can only come from an accepted second tail byte
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    (!out_valid && phase != PH_TAIL2) |=> !out_valid)
    else $error("result raised outside second tail byte");

  // After a new result the deframer is back hunting
  a_hunt_after: assert property (@(posedge clk) disable iff (rst)
    (frame_done) |=> (phase == PH_HEAD1 && out_valid))
    else $error("deframer not back in hunt after frame");

  // Payload counter stays inside the frame length
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DATA) |-> (payload_index < held_length))
    else $error("payload index past frame length");

  // Word frames always carry four bytes
  a_word_len: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (frame_kind == KIND_INT || frame_kind == KIND_FLOAT))
      |-> (payload_length == LEN_WORD && sum_computed == sum_received))
    else $error("word frame with bad length or sum");

endmodule

`default_nettype wire

// ----- dv/frame_check_pkg.sv -----
// Scoreboard for the checksummed frame receiver: a byte-level deframer predictor
// and an in-order queue of expected frame results.
// Depends on cfr_pkg for phases, result kinds, register indexes and sizes.

package frame_check_pkg;
  import cfr_pkg::*;

  // One frame result as seen on the output channel
  typedef struct packed {
    kind_t             kind;
    logic [WORD_W-1:0] value;
    logic [7:0]        code;
    logic [LEN_W-1:0]  len;
    logic [SUM_W-1:0]  sum_calc;
    logic [SUM_W-1:0]  sum_rx;
  } frame_result_t;

  class frame_scoreboard;
    logic [7:0]       regs [CFG_NUM];
    phase_t           phase;
    logic [7:0]       held_type;
    logic [LEN_W-1:0] held_len;
    int unsigned      data_idx;
    logic [7:0]       store [MAX_PAYLOAD];
    logic [SUM_W-1:0] run_sum;
    logic [SUM_W-1:0] rx_sum;
    frame_result_t    expected_q [$];
    int               mismatches;

    function new();
      foreach (regs[i]) regs[i] = CFG_RESET[i];
      foreach (store[i]) store[i] = '0;
      phase      = PH_HEAD1;
      held_type  = '0;
      held_len   = '0;
      data_idx   = 0;
      run_sum    = '0;
      rx_sum     = '0;
      mismatches = 0;
    endfunction

    function void write_reg(reg_idx_t idx, logic [7:0] v);
      regs[idx] = v;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // only the first ten failures are printed
    function void flag(string what);
      mismatches++;
      if (mismatches <= 10) $display("[%0t] mismatch: %s", $time, what);
    endfunction

    // Advance the deframer by one accepted byte; queue a result on a completed frame
    function void note_byte(logic [7:0] b);
      frame_result_t r;
      logic [WORD_W-1:0] word;
      case (phase)
        PH_HEAD2: begin
          // a wrong second header byte is not retried as a first one
          phase = (b == regs[REG_HEAD2]) ? PH_TYPE : PH_HEAD1;
        end
        PH_TYPE: begin
          held_type = b;
          run_sum   = SUM_W'(b);
          phase     = PH_LEN;
        end
        PH_LEN: begin
          held_len = (b > MAX_PAYLOAD) ? LEN_W'(MAX_PAYLOAD) : LEN_W'(b);
          data_idx = 0;
          run_sum  = run_sum + SUM_W'(held_len);
          phase    = (held_len != '0) ? PH_DATA : PH_SUMHI;
        end
        PH_DATA: begin
          if (data_idx < MAX_PAYLOAD) store[data_idx] = b;
          data_idx++;
          run_sum = run_sum + SUM_W'(b);
          if (data_idx >= held_len) phase = PH_SUMHI;
        end
        PH_SUMHI: begin
          rx_sum = {b, 8'h00};
          phase  = PH_SUMLO;
        end
        PH_SUMLO: begin
          rx_sum[7:0] = b;
          phase       = PH_TAIL1;
        end
        PH_TAIL1: begin
          phase = (b == regs[REG_TAIL1]) ? PH_TAIL2 : PH_HEAD1;
        end
        PH_TAIL2: begin
          phase = PH_HEAD1;
          if (b == regs[REG_TAIL2]) begin
            word       = {store[0], store[1], store[2], store[3]};
            r.value    = '0;
            r.code     = held_type;
            r.len      = held_len;
            r.sum_calc = run_sum;
            r.sum_rx   = rx_sum;
            // a sum mismatch wins first; then the first matching code wins, in int, float, ack, count order
            if (run_sum != rx_sum) begin
              r.kind = KIND_SUM_ERR;
            end else if (held_type == regs[REG_CODE_INT] && held_len == LEN_WORD) begin
              r.kind  = KIND_INT;
              r.value = word;
            end else if (held_type == regs[REG_CODE_FLOAT] && held_len == LEN_WORD) begin
              r.kind  = KIND_FLOAT;
              r.value = word;
            end else if (held_type == regs[REG_CODE_ACK] && held_len == LEN_ACK) begin
              r.kind = KIND_ACK;
            end else if (held_type == regs[REG_CODE_COUNT] && held_len == LEN_COUNT) begin
              r.kind  = KIND_COUNT;
              r.value = WORD_W'(store[0]);
            end else begin
              r.kind = KIND_UNKNOWN;
            end
            expected_q.push_back(r);
          end
        end
        default: begin
          phase = (b == regs[REG_HEAD1]) ? PH_HEAD2 : PH_HEAD1;
        end
      endcase
    endfunction

    // Compare one result transaction against the oldest expectation
    function void check_result(frame_result_t got);
      frame_result_t want;
      if (expected_q.size() == 0) begin
        flag($sformatf("result with nothing pending: kind %0d type %02h len %0d",
                       got.kind, got.code, got.len));
        return;
      end
      want = expected_q.pop_front();
      if (got.kind !== want.kind || got.value !== want.value || got.code !== want.code ||
          got.len !== want.len || got.sum_calc !== want.sum_calc ||
          got.sum_rx !== want.sum_rx)
        flag($sformatf({"exp kind %0d val %08h type %02h len %0d sum %04h/%04h, ",
                        "got kind %0d val %08h type %02h len %0d sum %04h/%04h"},
                       want.kind, want.value, want.code, want.len, want.sum_calc,
                       want.sum_rx, got.kind, got.value, got.code, got.len,
                       got.sum_calc, got.sum_rx));
    endfunction

    // Expectations that never showed up
    function void drop_leftovers();
      frame_result_t want;
      while (expected_q.size() != 0) begin
        want = expected_q.pop_front();
        flag($sformatf("missing result: kind %0d type %02h len %0d",
                       want.kind, want.code, want.len));
      end
    endfunction
  endclass

endpackage

// ----- dv/checksummed_frame_receiver_test.sv -----
// Top-level testbench for checksummed_frame_receiver: drives framed byte streams
// under several register settings and idle patterns, checks results in order.
// Depends on cfr_pkg and frame_check_pkg.

module checksummed_frame_receiver_test;
  timeunit 1ns;
  timeprecision 1ps;
  import cfr_pkg::*;
  import frame_check_pkg::*;

  typedef enum int {FLAW_NONE, FLAW_HEAD2, FLAW_TAIL1, FLAW_TAIL2} flaw_t;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]           cfg_data  = '0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  logic [7:0]           rx_byte   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [2:0]           frame_kind;
  logic [WORD_W-1:0]    payload_value;
  logic [7:0]           type_code;
  logic [LEN_W-1:0]     payload_length;
  logic [SUM_W-1:0]     sum_computed;
  logic [SUM_W-1:0]     sum_received;

  // register values currently loaded, used to build frames
  logic [7:0]      cfg [CFG_NUM];
  logic [7:0]      frame_body [MAX_PAYLOAD];
  int              idle_pct   = 0;
  int              stall_pct  = 0;
  int              bytes_sent = 0;
  frame_scoreboard sb = new();

  checksummed_frame_receiver dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .rx_byte        (rx_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .frame_kind     (frame_kind),
    .payload_value  (payload_value),
    .type_code      (type_code),
    .payload_length (payload_length),
    .sum_computed   (sum_computed),
    .sum_received   (sum_received)
  );

  // 2 ns clock
  initial begin
    forever #1 clk = ~clk;
  end

  // Hard stop in case the block hangs
  initial begin
    #2_000_000;
    $display("FAIL checksummed_frame_receiver");
    $finish;
  end

  // Random result-side stall
  always @(posedge clk) begin
    out_stall <= (int'($urandom_range(99)) < stall_pct);
  end

  // Watch both channels; transactions complete at this edge
  always @(posedge clk) begin : watch
    frame_result_t seen;
    if (!rst) begin
      if (in_valid && !in_stall) sb.note_byte(rx_byte);
      if (out_valid && !out_stall) begin
        seen.kind     = kind_t'(frame_kind);
        seen.value    = payload_value;
        seen.code     = type_code;
        seen.len      = payload_length;
        seen.sum_calc = sum_computed;
        seen.sum_rx   = sum_received;
        sb.check_result(seen);
      end
    end
  end

  // One byte transaction, with optional idle cycles in front
  task automatic send_byte(input logic [7:0] b);
    while (int'($urandom_range(99)) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    bytes_sent++;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Load every register from cfg; block must be idle
  task automatic apply_config();
    for (int i = 0; i < CFG_NUM; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data  <= cfg[i];
      sb.write_reg(reg_idx_t'(i), cfg[i]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // Stop sending and wait for outstanding results, bounded
  task automatic settle();
    int waited;
    in_valid <= 1'b0;
    waited = 0;
    @(posedge clk);
    while (sb.pending() != 0 && waited < 1000) begin
      @(posedge clk);
      waited++;
    end
    sb.drop_leftovers();
    repeat (4) @(posedge clk);
  endtask

  // Build and send one frame around frame_body; flaw picks a deliberate defect
  task automatic send_frame(input logic [7:0] ftype, input logic [7:0] len_byte,
                            input logic [SUM_W-1:0] sum_flip, input flaw_t flaw);
    int               n;
    logic [SUM_W-1:0] sum;
    n   = (len_byte > MAX_PAYLOAD) ? int'(MAX_PAYLOAD) : int'(len_byte);
    sum = SUM_W'(ftype) + SUM_W'(n);
    for (int i = 0; i < n; i++) sum = sum + SUM_W'(frame_body[i]);
    sum = sum ^ sum_flip;
    send_byte(cfg[REG_HEAD1]);
    if (flaw == FLAW_HEAD2) begin
      // a repeated first header byte must not be taken as a new first header byte
      if (cfg[REG_HEAD1] != cfg[REG_HEAD2] && $urandom_range(1) == 1)
        send_byte(cfg[REG_HEAD1]);
      else
        send_byte(cfg[REG_HEAD2] ^ 8'($urandom_range(1, 255)));
      return;
    end
    send_byte(cfg[REG_HEAD2]);
    send_byte(ftype);
    send_byte(len_byte);
    for (int i = 0; i < n; i++) send_byte(frame_body[i]);
    send_byte(sum[15:8]);
    send_byte(sum[7:0]);
    send_byte((flaw == FLAW_TAIL1) ? ~cfg[REG_TAIL1] : cfg[REG_TAIL1]);
    if (flaw != FLAW_TAIL1)
      send_byte((flaw == FLAW_TAIL2) ? ~cfg[REG_TAIL2] : cfg[REG_TAIL2]);
  endtask

  // Mostly well-formed frames with random content, some broken ones and line noise
  task automatic run_random(input int budget);
    int               stop_at;
    int               roll;
    logic [7:0]       filler;
    logic [7:0]       ftype;
    logic [7:0]       len_byte;
    logic [SUM_W-1:0] flip;
    flaw_t            flaw;
    stop_at = bytes_sent + budget;
    while (bytes_sent < stop_at) begin
      // noise, then a run of filler that drives the deframer back to the hunt
      if ($urandom_range(99) < 8) begin
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
        do filler = 8'($urandom);
        while (filler == cfg[REG_HEAD1] || filler == cfg[REG_HEAD2] ||
               filler == cfg[REG_TAIL1] || filler == cfg[REG_TAIL2]);
        repeat (14) send_byte(filler);
      end
      foreach (frame_body[i]) frame_body[i] = 8'($urandom);
      ftype    = 8'($urandom);
      len_byte = 8'($urandom_range(MAX_PAYLOAD));
      case ($urandom_range(9))
        0, 1: begin
          ftype    = cfg[REG_CODE_INT];
          len_byte = 8'(LEN_WORD);
        end
        2, 3: begin
          ftype    = cfg[REG_CODE_FLOAT];
          len_byte = 8'(LEN_WORD);
        end
        4: begin
          ftype    = cfg[REG_CODE_ACK];
          len_byte = 8'(LEN_ACK);
        end
        5, 6: begin
          ftype    = cfg[REG_CODE_COUNT];
          len_byte = 8'(LEN_COUNT);
        end
        // known code with a length that may not fit it
        7: ftype = cfg[CFG_IDX_W'(REG_CODE_INT) + CFG_IDX_W'($urandom_range(3))];
        // any length byte, mostly clamped
        8: len_byte = 8'($urandom);
        default: ;
      endcase
      roll = int'($urandom_range(99));
      flip = (roll < 10) ? SUM_W'($urandom_range(1, 16'hFFFF)) :
             (roll < 15) ? SUM_W'(1) : '0;
      roll = int'($urandom_range(99));
      flaw = (roll < 5) ? FLAW_HEAD2 : (roll < 10) ? FLAW_TAIL1 :
             (roll < 15) ? FLAW_TAIL2 : FLAW_NONE;
      send_frame(ftype, len_byte, flip, flaw);
    end
  endtask

  // Main sequence
  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset register values, no idling
    foreach (cfg[i]) cfg[i] = CFG_RESET[i];
    apply_config();
    foreach (frame_body[i]) frame_body[i] = 8'hFF;
    send_frame(cfg[REG_CODE_INT], 8'(LEN_WORD), '0, FLAW_NONE);
    send_byte(cfg[REG_HEAD1]);
    send_byte(cfg[REG_HEAD1]);
    send_frame(cfg[REG_CODE_ACK], 8'(LEN_ACK), '0, FLAW_NONE);
    frame_body[0] = 8'h00;
    send_frame(cfg[REG_CODE_COUNT], 8'(LEN_COUNT), '0, FLAW_NONE);
    run_random(130);
    settle();

    // extreme register values, sender idles often
    cfg[REG_HEAD1]      = 8'h00;
    cfg[REG_HEAD2]      = 8'hFF;
    cfg[REG_TAIL1]      = 8'hFF;
    cfg[REG_TAIL2]      = 8'h00;
    cfg[REG_CODE_INT]   = 8'hFF;
    cfg[REG_CODE_FLOAT] = 8'h00;
    cfg[REG_CODE_ACK]   = 8'h80;
    cfg[REG_CODE_COUNT] = 8'h7F;
    idle_pct  = 61;
    stall_pct = 0;
    apply_config();
    run_random(170);
    settle();

    // random values with shared codes, receiver stalls often
    foreach (cfg[i]) cfg[i] = 8'($urandom);
    cfg[REG_CODE_FLOAT] = cfg[REG_CODE_INT];
    cfg[REG_CODE_COUNT] = cfg[REG_CODE_ACK];
    idle_pct  = 0;
    stall_pct = 61;
    apply_config();
    run_random(170);
    settle();

    // opposite extremes, all codes equal, both sides idle
    cfg[REG_HEAD1]      = 8'hFF;
    cfg[REG_HEAD2]      = 8'h00;
    cfg[REG_TAIL1]      = 8'h00;
    cfg[REG_TAIL2]      = 8'hFF;
    cfg[REG_CODE_INT]   = 8'h00;
    cfg[REG_CODE_FLOAT] = 8'h00;
    cfg[REG_CODE_ACK]   = 8'h00;
    cfg[REG_CODE_COUNT] = 8'h00;
    idle_pct  = 34;
    stall_pct = 34;
    apply_config();
    run_random(170);
    settle();

    // fully random values, back to back
    foreach (cfg[i]) cfg[i] = 8'($urandom);
    idle_pct  = 0;
    stall_pct = 0;
    apply_config();
    run_random(170);
    settle();

    if (sb.mismatches == 0) begin
      $display("PASS checksummed_frame_receiver");
    end else begin
      $display("FAIL checksummed_frame_receiver");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/cfr_pkg.sv
rtl/checksummed_frame_receiver.sv
dv/frame_check_pkg.sv
dv/checksummed_frame_receiver_test.sv
